@@ src/assert_macros.svh @@
// Assertion helpers used by the encoder sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside of reset.
`define IRPE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// The consequent must hold in the clock cycle after the antecedent.
`define IRPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define IRPE_ASSERT(lbl, clk, rst, prop)
`define IRPE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ src/irpe_pkg.sv @@
package irpe_pkg;

   typedef struct packed {
      logic        opcode;
      logic [63:0] payload;
      logic [6:0]  bit_count;
      logic [15:0] repeat_count;
   } irpe_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       ir_on;
      logic       busy_res;
      logic       done_res;
   } irpe_rsp_type;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] STATUS_TICK   = 2'd0;
   localparam logic [1:0] STATUS_ACCEPT = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   // Segment lengths in protocol units.
   localparam logic [3:0] HDR_MARK_UNITS   = 4'd8;
   localparam logic [3:0] HDR_SPACE_UNITS  = 4'd8;
   localparam logic [3:0] BIT_MARK_UNITS   = 4'd1;
   localparam logic [3:0] ONE_SPACE_UNITS  = 4'd3;
   localparam logic [3:0] ZERO_SPACE_UNITS = 4'd1;
   localparam logic [3:0] FOOT_MARK_UNITS  = 4'd1;
   localparam logic [3:0] GAP_UNITS        = 4'd9;

endpackage

@@ src/ir_inverted_byte_pulse_encoder_top.sv @@
// Pulse-distance infrared envelope encoder: a load item latches a message of up to MAX_BITS
// bits (a whole number of bytes) and a repeat count, and every tick item then advances the
// transmission by one protocol unit and returns the envelope level for that unit; each byte
// is sent MSB first followed by its complement, between an 8+8 unit header and a footer mark
// with a 9 unit gap. Every item, load or tick, produces exactly one result item. The block
// takes one item per clock cycle; a result appears in the output register in the cycle after
// its item is accepted, and the input stays ready as long as that register is empty or is
// being drained in the same cycle.
module ir_inverted_byte_pulse_encoder_top #(
   parameter int MAX_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  irpe_pkg::irpe_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output irpe_pkg::irpe_rsp_type rsp_data
);
   import irpe_pkg::*;

   logic         step;
   logic         rsp_valid_ff, rsp_valid_in;
   irpe_rsp_type rsp_data_ff;
   irpe_rsp_type seq_rsp;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign step         = req_valid && req_ready;
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   irpe_seq #(
      .MAX_BITS(MAX_BITS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .step_i(step),
      .req_i (req_data),
      .rsp_o (seq_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= seq_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/irpe_seq.sv @@
`include "assert_macros.svh"

module irpe_seq #(
   parameter int MAX_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_i,
   input  irpe_pkg::irpe_req_type req_i,
   output irpe_pkg::irpe_rsp_type rsp_o
);
   import irpe_pkg::*;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_HDR_MARK  = 3'd1;
   localparam logic [2:0] PH_HDR_SPACE = 3'd2;
   localparam logic [2:0] PH_BIT_MARK  = 3'd3;
   localparam logic [2:0] PH_BIT_SPACE = 3'd4;
   localparam logic [2:0] PH_FOOT_MARK = 3'd5;
   localparam logic [2:0] PH_GAP       = 3'd6;

   logic [MAX_BITS-1:0] held_payload_ff, held_payload_in;
   logic [6:0]  held_bit_count_ff, held_bit_count_in;
   logic [15:0] repeats_left_ff, repeats_left_in;
   logic [3:0]  byte_index_ff, byte_index_in;
   logic [2:0]  bit_index_ff, bit_index_in;
   logic        complement_ff, complement_in;
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  units_left_ff, units_left_in;

   logic        is_busy;
   logic        load_ok;
   logic [3:0]  byte_total;
   logic [3:0]  byte_sel;
   logic [3:0]  byte_next;
   logic [63:0] byte_window;
   logic [7:0]  seg_byte;
   logic        cur_bit;
   logic [3:0]  units_dec;

   // Bytes of the held message go out most significant first.
   always_comb begin
      byte_total  = held_bit_count_ff[6:3];
      byte_sel    = byte_total - 4'd1 - byte_index_ff;
      byte_window = 64'(held_payload_ff) >> {byte_sel[2:0], 3'b000};
      seg_byte    = byte_window[7:0] ^ {8{complement_ff}};
      cur_bit     = (byte_index_ff < byte_total) ? seg_byte[3'd7 - bit_index_ff] : 1'b0;
   end

   always_comb begin
      held_payload_in   = held_payload_ff;
      held_bit_count_in = held_bit_count_ff;
      repeats_left_in   = repeats_left_ff;
      byte_index_in     = byte_index_ff;
      bit_index_in      = bit_index_ff;
      complement_in     = complement_ff;
      phase_in          = phase_ff;
      units_left_in     = units_left_ff;
      rsp_o             = '0;
      is_busy           = phase_ff != PH_IDLE;
      load_ok           = 1'b0;
      units_dec         = units_left_ff - 4'd1;
      byte_next         = byte_index_ff + 4'd1;

      if (req_i.opcode == OP_LOAD) begin
         load_ok = !is_busy && (req_i.bit_count[2:0] == 3'd0)
                   && (req_i.bit_count <= 7'(MAX_BITS));
         if (load_ok) begin
            held_payload_in   = req_i.payload[MAX_BITS-1:0];
            held_bit_count_in = req_i.bit_count;
            repeats_left_in   = req_i.repeat_count;
            byte_index_in     = 4'd0;
            bit_index_in      = 3'd0;
            complement_in     = 1'b0;
            phase_in          = PH_HDR_MARK;
            units_left_in     = HDR_MARK_UNITS;
         end
         rsp_o.status   = load_ok ? STATUS_ACCEPT : STATUS_REJECT;
         rsp_o.busy_res = load_ok || is_busy;
      end else begin
         rsp_o.status = STATUS_TICK;
         if (is_busy) begin
            if (phase_ff > PH_GAP || units_left_ff == 4'd0) begin
               // Corrupt segment state: fall back to idle with a space.
               phase_in      = PH_IDLE;
               units_left_in = 4'd0;
            end else begin
               rsp_o.ir_on   = (phase_ff == PH_HDR_MARK) || (phase_ff == PH_BIT_MARK)
                               || (phase_ff == PH_FOOT_MARK);
               units_left_in = units_dec;
               if (units_dec == 4'd0) begin
                  case (phase_ff)
                     PH_HDR_MARK: begin
                        phase_in      = PH_HDR_SPACE;
                        units_left_in = HDR_SPACE_UNITS;
                     end
                     PH_HDR_SPACE: begin
                        byte_index_in = 4'd0;
                        bit_index_in  = 3'd0;
                        complement_in = 1'b0;
                        if (held_bit_count_ff >= 7'd8) begin
                           phase_in      = PH_BIT_MARK;
                           units_left_in = BIT_MARK_UNITS;
                        end else begin
                           phase_in      = PH_FOOT_MARK;
                           units_left_in = FOOT_MARK_UNITS;
                        end
                     end
                     PH_BIT_MARK: begin
                        phase_in      = PH_BIT_SPACE;
                        units_left_in = cur_bit ? ONE_SPACE_UNITS : ZERO_SPACE_UNITS;
                     end
                     PH_BIT_SPACE: begin
                        phase_in      = PH_BIT_MARK;
                        units_left_in = BIT_MARK_UNITS;
                        if (bit_index_ff != 3'd7) begin
                           bit_index_in = bit_index_ff + 3'd1;
                        end else if (!complement_ff) begin
                           bit_index_in  = 3'd0;
                           complement_in = 1'b1;
                        end else begin
                           bit_index_in  = 3'd0;
                           complement_in = 1'b0;
                           byte_index_in = byte_next;
                           if (byte_next >= byte_total) begin
                              phase_in      = PH_FOOT_MARK;
                              units_left_in = FOOT_MARK_UNITS;
                           end
                        end
                     end
                     PH_FOOT_MARK: begin
                        phase_in      = PH_GAP;
                        units_left_in = GAP_UNITS;
                     end
                     default: begin
                        if (repeats_left_ff != 16'd0) begin
                           repeats_left_in = repeats_left_ff - 16'd1;
                           phase_in        = PH_HDR_MARK;
                           units_left_in   = HDR_MARK_UNITS;
                        end else begin
                           phase_in       = PH_IDLE;
                           rsp_o.done_res = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         rsp_o.busy_res = phase_in != PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_payload_ff   <= '0;
         held_bit_count_ff <= '0;
         repeats_left_ff   <= '0;
         byte_index_ff     <= '0;
         bit_index_ff      <= '0;
         complement_ff     <= 1'b0;
         phase_ff          <= PH_IDLE;
         units_left_ff     <= '0;
      end else if (step_i) begin
         held_payload_ff   <= held_payload_in;
         held_bit_count_ff <= held_bit_count_in;
         repeats_left_ff   <= repeats_left_in;
         byte_index_ff     <= byte_index_in;
         bit_index_ff      <= bit_index_in;
         complement_ff     <= complement_in;
         phase_ff          <= phase_in;
         units_left_ff     <= units_left_in;
      end
   end

   `IRPE_ASSERT(a_idle_no_units, clock, reset, (phase_ff == PH_IDLE) == (units_left_ff == 4'd0))
   `IRPE_ASSERT(a_held_count_legal, clock, reset, held_bit_count_ff[2:0] == 3'd0 && held_bit_count_ff <= 7'(MAX_BITS))
   `IRPE_ASSERT(a_byte_in_range, clock, reset, !(phase_ff == PH_BIT_MARK || phase_ff == PH_BIT_SPACE) || byte_index_ff < held_bit_count_ff[6:3])
   `IRPE_ASSERT_NEXT(a_done_goes_idle, clock, reset, step_i && rsp_o.done_res, phase_ff == PH_IDLE)

endmodule
